FILE: design/sdf_pkg.sv
// Shared constants and types of the sequence duplicate filter.
package sdf_pkg;

    // Sequence number space
    localparam int SEQ_WIDTH = 16;

    // Seen-map block layout: four blocks of 16384 sequences each
    localparam int BLOCK_COUNT = 4;
    localparam int BLOCK_IDX_W = 2;
    localparam int BLOCK_SIZE  = 16384;

    // Default width of one seen-map word (power of two, 8 to 64)
    localparam int WORD_WIDTH_DEF = 32;

    // Window indices after reset
    localparam logic [BLOCK_IDX_W-1:0] OLDEST_RESET = 2'd0;
    localparam logic [BLOCK_IDX_W-1:0] NEWEST_RESET = 2'd1;

    // Distance from the newest block to the block just behind the oldest
    localparam logic [BLOCK_IDX_W-1:0] BEHIND_OFFSET = 2'd2;

    // Window status handed from the window tracker to the controller
    typedef struct packed {
        logic                   need_advance;
        logic [BLOCK_IDX_W-1:0] oldest;
    } win_stat_t;

endpackage

FILE: design/sequence_duplicate_filter.sv
// Top level of the sequence duplicate filter: controller, seen-map and window.
//
// One request on the s_ channel carries a 16-bit sequence number; one result
// on the m_ channel tells whether it is new (and now recorded) and whether the
// window advanced, which clears the oldest 16384-sequence block.
// Both channels use valid/ready; a request is taken when s_valid and s_ready
// are high at a rising edge of aclk.
// The result is registered: m_valid is set at the end of the check step that
// follows acceptance, once the output register is free.
// One request is handled at a time: s_ready stays low during the
// read-modify-write of one seen-map word through the single-ported-read
// memory. A request that moves the window also keeps s_ready low while
// the old block is swept to zero, one word per cycle.
// Reset (aresetn low, synchronous) starts a clearing pass over all DEPTH
// words of the seen-map; s_ready stays low until it
// ends. The result sits in an output register: a new request is taken while
// the previous result still waits, but the next result holds in the check
// step until the receiver drains m_valid.
// WORD_WIDTH must be a power of two from 8 to 64.
module sequence_duplicate_filter
    import sdf_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SEQ_WIDTH-1:0] s_sequence_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_new,
    output logic                 m_window_advanced
);

    localparam int DEPTH     = (1 << SEQ_WIDTH) / WORD_WIDTH;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int BIT_W     = $clog2(WORD_WIDTH);
    localparam int BLK_WORDS = DEPTH / BLOCK_COUNT;
    localparam int BLK_W     = $clog2(BLK_WORDS);

    // Controller states
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [ADDR_W-1:0]     sweep_cnt_reg;
    logic [ADDR_W-1:0]     sweep_cnt_next;
    logic [SEQ_WIDTH-1:0]  seq_reg;
    logic [BLOCK_IDX_W-1:0] clr_blk_reg;
    logic [BLOCK_IDX_W-1:0] clr_blk_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_is_new_reg;
    logic                  m_adv_reg;

    logic                  accept;
    logic                  out_free;
    logic                  check_fire;
    logic                  hit;
    logic                  adv;
    logic [WORD_WIDTH-1:0] rd_data;
    logic [WORD_WIDTH-1:0] bit_mask;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    win_stat_t             win_stat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Lookup of the request's bit in the word read back
    assign bit_mask   = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << seq_reg[BIT_W-1:0];
    assign hit        = |(rd_data & bit_mask);
    assign adv        = !hit && win_stat.need_advance;
    assign check_fire = (state_reg == ST_CHECK) && out_free;

    sdf_seen_ram #(
        .WIDTH  (WORD_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (s_sequence_req[SEQ_WIDTH-1:BIT_W]),
        .rdata (rd_data)
    );

    sdf_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seq_block (seq_reg[SEQ_WIDTH-1:SEQ_WIDTH-BLOCK_IDX_W]),
        .step      (check_fire && adv),
        .stat      (win_stat)
    );

    // Memory write select: sweeps write zero, the check step sets the bit
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = seq_reg[SEQ_WIDTH-1:BIT_W];
        ram_wdata = rd_data | bit_mask;
        unique case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = '0;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = {clr_blk_reg, sweep_cnt_reg[BLK_W-1:0]};
                ram_wdata = '0;
            end
            ST_CHECK: begin
                ram_we = check_fire && !hit;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Controller next state
    always_comb begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        clr_blk_next   = clr_blk_reg;
        unique case (state_reg)
            ST_INIT: begin
                sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
                if (sweep_cnt_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (check_fire) begin
                    sweep_cnt_next = '0;
                    clr_blk_next   = win_stat.oldest;
                    state_next     = adv ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR: begin
                sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
                if (sweep_cnt_reg[BLK_W-1:0] == {BLK_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            sweep_cnt_reg <= '0;
            clr_blk_reg   <= OLDEST_RESET;
        end else begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            clr_blk_reg   <= clr_blk_next;
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= s_sequence_req;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (check_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (check_fire) begin
            m_is_new_reg <= !hit;
            m_adv_reg    <= adv;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_is_new          = m_is_new_reg;
    assign m_window_advanced = m_adv_reg;

    // A window move only comes with a newly recorded sequence
    a_adv_is_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_window_advanced) |-> m_is_new)
        else $error("window advanced on a duplicate");

    // A window move starts the block sweep
    a_adv_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (check_fire && adv) |=> (state_reg == ST_CLEAR))
        else $error("window advanced without block sweep");

    // The sweep never touches the block the recorded sequence lives in
    a_sweep_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR)
        |-> (clr_blk_reg != seq_reg[SEQ_WIDTH-1:SEQ_WIDTH-BLOCK_IDX_W]))
        else $error("sweep hits the block just recorded");

    // No request is taken while a sweep runs
    a_no_accept_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)) |-> !s_ready)
        else $error("request taken during sweep");

endmodule

FILE: design/sdf_seen_ram.sv
// Seen-map memory: one write port, one read port with registered read data.
module sdf_seen_ram
    import sdf_pkg::*;
#(
    parameter int WIDTH  = WORD_WIDTH_DEF,
    parameter int DEPTH  = (1 << SEQ_WIDTH) / WORD_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sdf_window.sv
// Window tracker: oldest and newest block indices and the advance decision.
module sdf_window
    import sdf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [BLOCK_IDX_W-1:0] seq_block,
    input  logic                   step,
    output win_stat_t              stat
);

    logic [BLOCK_IDX_W-1:0] oldest_reg;
    logic [BLOCK_IDX_W-1:0] oldest_next;
    logic [BLOCK_IDX_W-1:0] newest_reg;
    logic [BLOCK_IDX_W-1:0] newest_next;
    logic [BLOCK_IDX_W-1:0] behind;

    // Block just behind the oldest; index math wraps modulo the block count
    assign behind = newest_reg + BEHIND_OFFSET;

    assign stat.need_advance = (seq_block != oldest_reg) && (seq_block != newest_reg)
                               && (seq_block != behind);
    assign stat.oldest       = oldest_reg;

    // Advance both indices by one block
    always_comb begin
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        if (step) begin
            oldest_next = newest_reg;
            newest_next = newest_reg + BLOCK_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= OLDEST_RESET;
            newest_reg <= NEWEST_RESET;
        end else begin
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
        end
    end

endmodule
